### hw/rtl/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and constants for the ordered list block: operation codes,
// field widths and the bus broadcast from the top level to every list cell.
// ----------------------------------------------------------------------------
package olist_pkg;

   localparam int DATA_W    = 32;
   localparam int POS_W     = 7;
   localparam int CNT_OUT_W = 7;
   localparam int GRP_SIZE  = 8;   // match bits checked per locate scan cycle

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_GET    = 2'd2,
      OP_LOCATE = 2'd3
   } op_type;

   // Broadcast to all cells in the cycle a request is accepted
   typedef struct packed {
      logic                     ins;    // accepted insert that succeeds
      logic                     loc;    // accepted locate: capture compare result
      logic [POS_W-1:0]         pos0;   // 0-based insert index
      logic signed [DATA_W-1:0] value;  // value to insert or search for
   } cell_bus_type;

endpackage

### hw/rtl/olist_cell.sv
// ----------------------------------------------------------------------------
// olist_cell
// One list entry. On insert it loads the new value, takes its left
// neighbor's entry or holds; on locate it registers an equality match.
// ----------------------------------------------------------------------------
module olist_cell #(
   parameter int IDX_W = 6
) (
   input  logic                               clock,
   input  logic [IDX_W-1:0]                   cell_idx,
   input  olist_pkg::cell_bus_type            bus,
   input  logic signed [olist_pkg::DATA_W-1:0] left_value,
   output logic signed [olist_pkg::DATA_W-1:0] entry_value,
   output logic                               match
);

   localparam int CW = (IDX_W > olist_pkg::POS_W) ? IDX_W : olist_pkg::POS_W;

   logic signed [olist_pkg::DATA_W-1:0] entry_ff, entry_in;
   logic                                match_ff, match_in;
   logic [CW-1:0]                       idx_c, pos_c;

   assign idx_c = CW'(cell_idx);
   assign pos_c = CW'(bus.pos0);

   always_comb begin
      entry_in = entry_ff;
      if (bus.ins) begin
         if (idx_c == pos_c) begin
            entry_in = bus.value;
         end else if (idx_c > pos_c) begin
            entry_in = left_value;
         end
      end
      match_in = bus.loc ? (entry_ff == bus.value) : match_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry_value = entry_ff;
   assign match       = match_ff;

endmodule

### hw/rtl/ordered_list_insert_get_locate.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_get_locate
// Bounded ordered list of signed 32-bit entries held in a row of cells.
// ----------------------------------------------------------------------------
// Clear, insert and get results strobe in the cycle after the request is
// accepted; busy stays low, so a new request may be issued every cycle.
// Insert shifts all cells above the insert point in parallel. Locate
// compares every cell at once, then a group scanner walks the match bits
// eight cells per cycle while busy is high; the result strobes in the same
// cycle in which busy falls. Results cannot be held off: rsp_valid is high
// for exactly one cycle per request.
// ----------------------------------------------------------------------------
module ordered_list_insert_get_locate #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_item_value,
   input  logic [6:0]         req_position,
   output logic               rsp_valid,
   output logic               rsp_ok,
   output logic signed [31:0] rsp_read_value,
   output logic [6:0]         rsp_found_position,
   output logic [6:0]         rsp_entry_count,
   output logic               rsp_is_empty
);

   localparam int DW       = olist_pkg::DATA_W;
   localparam int PW       = olist_pkg::POS_W;
   localparam int GS       = olist_pkg::GRP_SIZE;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int NGRP     = (CAPACITY + GS - 1) / GS;
   localparam int GRP_W    = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int FIRST_W  = $clog2(GS);
   localparam int SCAN_W   = GRP_W + FIRST_W + 1;
   localparam int CMP_W    = ((CNT_W > PW) ? CNT_W : PW) + 1;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type                 state_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [GRP_W-1:0]          grp_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_ok_ff;
   logic signed [DW-1:0]      rsp_read_ff;
   logic [6:0]                rsp_found_ff;

   logic signed [DW-1:0]      entry [CAPACITY];
   logic                      match [CAPACITY];
   logic [GS-1:0]             grp_bits [NGRP];
   olist_pkg::cell_bus_type   bus;

   logic                      accept;
   logic                      ins_ok;
   logic                      get_ok;
   logic [CMP_W-1:0]          pos_w, cnt_w;
   logic [PW-1:0]             pos0;
   logic [IDX_W-1:0]          get_idx;
   logic [GS-1:0]             cur_bits;
   logic                      hit;
   logic [FIRST_W-1:0]        first;
   logic [CNT_W-1:0]          hit_pos;
   logic [SCAN_W-1:0]         next_base;
   logic                      scan_end;

   assign busy   = (state_ff == ST_SCAN);
   assign accept = start && !busy;
   assign pos_w  = CMP_W'(req_position);
   assign cnt_w  = CMP_W'(count_ff);
   assign pos0   = req_position - PW'(1);

   assign ins_ok = (req_position != '0) && (pos_w <= cnt_w + CMP_W'(1)) &&
                   (count_ff != CNT_W'(CAPACITY));
   assign get_ok = (req_position != '0) && (pos_w <= cnt_w);
   assign get_idx = IDX_W'(pos0);

   assign bus.ins   = accept && (req_op == olist_pkg::OP_INSERT) && ins_ok;
   assign bus.loc   = accept && (req_op == olist_pkg::OP_LOCATE);
   assign bus.pos0  = pos0;
   assign bus.value = req_item_value;

   // Row of cells; each takes its left neighbor's entry on a shift
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic signed [DW-1:0] left_value;
      if (k == 0) begin : g_first
         assign left_value = req_item_value;
      end else begin : g_rest
         assign left_value = entry[k-1];
      end
      olist_cell #(
         .IDX_W(IDX_W)
      ) u_cell (
         .clock       (clock),
         .cell_idx    (IDX_W'(k)),
         .bus         (bus),
         .left_value  (left_value),
         .entry_value (entry[k]),
         .match       (match[k])
      );
   end

   // Match bits in groups, masked to live entries
   for (genvar g = 0; g < NGRP; g++) begin : g_grp
      for (genvar b = 0; b < GS; b++) begin : g_bit
         localparam int K = g * GS + b;
         if (K < CAPACITY) begin : g_live
            assign grp_bits[g][b] = match[K] && (CNT_W'(K) < count_ff);
         end else begin : g_pad
            assign grp_bits[g][b] = 1'b0;
         end
      end
   end

   assign cur_bits = grp_bits[grp_ff];

   always_comb begin
      hit   = 1'b0;
      first = '0;
      for (int b = GS - 1; b >= 0; b--) begin
         if (cur_bits[b]) begin
            hit   = 1'b1;
            first = FIRST_W'(b);
         end
      end
   end

   assign hit_pos   = CNT_W'({grp_ff, first}) + CNT_W'(1);
   assign next_base = SCAN_W'({grp_ff, {FIRST_W{1'b0}}}) + SCAN_W'(GS);
   assign scan_end  = next_base >= SCAN_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rsp_read_ff  <= '0;
                  rsp_found_ff <= '0;
                  case (req_op)
                     olist_pkg::OP_CLEAR: begin
                        count_ff     <= '0;
                        rsp_ok_ff    <= 1'b1;
                        rsp_valid_ff <= 1'b1;
                     end
                     olist_pkg::OP_INSERT: begin
                        if (ins_ok) begin
                           count_ff <= count_ff + CNT_W'(1);
                        end
                        rsp_ok_ff    <= ins_ok;
                        rsp_valid_ff <= 1'b1;
                     end
                     olist_pkg::OP_GET: begin
                        rsp_ok_ff    <= get_ok;
                        rsp_read_ff  <= get_ok ? entry[get_idx] : '0;
                        rsp_valid_ff <= 1'b1;
                     end
                     olist_pkg::OP_LOCATE: begin
                        grp_ff   <= '0;
                        state_ff <= ST_SCAN;
                     end
                     default: begin
                        rsp_ok_ff <= 1'b0;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (hit || scan_end) begin
                  rsp_ok_ff    <= 1'b1;
                  rsp_read_ff  <= '0;
                  rsp_found_ff <= hit ? 7'(hit_pos) : '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  grp_ff <= grp_ff + GRP_W'(1);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_read_value     = rsp_read_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_entry_count    = 7'(count_ff);
   assign rsp_is_empty       = (count_ff == '0);

   // No result strobes while a locate scan is running
   a_no_rsp_in_scan: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("result strobe during locate scan");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op != olist_pkg::OP_LOCATE) |=> rsp_valid)
      else $error("missing result for clear, insert or get");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      (bus.ins) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not advance entry count");

endmodule
